// ===== src/mdf_pkg.sv =====
// Package for the modular divider: field widths, prime, Barrett constant,
// exponent and multiplier latency. No dependencies.
package mdf_pkg;

    localparam int unsigned W = 30;
    localparam logic [W-1:0] PRIME = 30'd998244353;
    // Fermat exponent, prime minus two
    localparam logic [W-1:0] EXPO = PRIME - 30'd2;
    localparam int unsigned ROUNDS = W;
    // Barrett reciprocal floor(2^60 / prime), fits in 31 bits
    localparam logic [60:0] TWO_POW_60 = 61'd1 << 60;
    localparam logic [60:0] MU_WIDE = TWO_POW_60 / {31'd0, PRIME};
    localparam logic [30:0] MU = MU_WIDE[30:0];
    // Register stages in one modular multiplier
    localparam int unsigned MUL_LAT = 4;

    typedef logic [W-1:0] t_word;

endpackage

// ===== src/mdf_if.sv =====
// Valid/ready channels of the modular divider: input pair and result.
// No dependencies.
interface mdf_in_if;
    logic valid;
    logic ready;
    logic [29:0] dividend;
    logic [29:0] divisor;
    modport source (output valid, output dividend, output divisor, input ready);
    modport sink (input valid, input dividend, input divisor, output ready);
    modport monitor (input valid, input dividend, input divisor, input ready);
endinterface

interface mdf_out_if;
    logic valid;
    logic ready;
    logic [29:0] quotient;
    modport source (output valid, output quotient, input ready);
    modport sink (input valid, input quotient, output ready);
    modport monitor (input valid, input quotient, input ready);
endinterface

// ===== src/mdf_modmul.sv =====
// Four-stage modular multiplier a*b mod prime using Barrett reduction.
// Depends on mdf_pkg.
module mdf_modmul (
    input  logic          i_clk,
    input  logic          i_en,
    input  mdf_pkg::t_word i_a,
    input  mdf_pkg::t_word i_b,
    output mdf_pkg::t_word o_p
);
    import mdf_pkg::*;

    logic [59:0] r_prod;
    logic [61:0] r_q2;
    logic [31:0] r_lo2;
    logic [31:0] r_qp;
    logic [31:0] r_lo3;
    t_word       r_res;
    logic [61:0] n_q2;
    logic [61:0] n_qp;
    logic [31:0] n_rem;
    logic [31:0] n_rem1;
    logic [31:0] n_rem2;

    // Estimate the quotient and its multiple of the prime, then reduce the remainder
    always_comb begin
        n_q2 = {31'd0, r_prod[59:29]} * {31'd0, MU};
        n_qp = {31'd0, r_q2[61:31]} * {32'd0, PRIME};
        n_rem = r_lo3 - r_qp;
        n_rem1 = (n_rem >= {2'b00, PRIME}) ? n_rem - {2'b00, PRIME} : n_rem;
        n_rem2 = (n_rem1 >= {2'b00, PRIME}) ? n_rem1 - {2'b00, PRIME} : n_rem1;
    end

    // Advance the stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= {30'd0, i_a} * {30'd0, i_b};
            r_q2   <= n_q2;
            r_lo2  <= r_prod[31:0];
            r_qp   <= n_qp[31:0];
            r_lo3  <= r_lo2;
            r_res  <= n_rem2[W-1:0];
        end
    end

    assign o_p = r_res;
endmodule

// ===== src/mdf_round.sv =====
// One square-and-multiply round: square the base, multiply the accumulator
// when the exponent bit is set, else delay it. Depends on mdf_pkg, mdf_modmul.
module mdf_round #(
    parameter bit DO_MUL = 1'b1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  mdf_pkg::t_word i_acc,
    input  mdf_pkg::t_word i_base,
    output mdf_pkg::t_word o_acc,
    output mdf_pkg::t_word o_base
);
    import mdf_pkg::*;

    // Square the base
    mdf_modmul u_sq (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_base),
        .i_b   (i_base),
        .o_p   (o_base)
    );

    generate
        if (DO_MUL) begin : g_mul
            mdf_modmul u_mul (
                .i_clk (i_clk),
                .i_en  (i_en),
                .i_a   (i_acc),
                .i_b   (i_base),
                .o_p   (o_acc)
            );
        end else begin : g_dly
            t_word r_dly [MUL_LAT];
            // Hold the accumulator in step with the squarer
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dly[0] <= i_acc;
                    for (int k = 1; k < MUL_LAT; k++) begin
                        r_dly[k] <= r_dly[k-1];
                    end
                end
            end
            assign o_acc = r_dly[MUL_LAT-1];
        end
    endgenerate
endmodule

// ===== src/modular_division_fermat_top.sv =====
// Modular divider: quotient = dividend * divisor^(prime-2) mod 998244353.
// The pipeline is one input reduction stage, then 30 rounds of four-stage
// Barrett multipliers. Throughput one item per cycle; a stalled output
// freezes the whole pipeline. Reset (synchronous, active low) clears the
// valid bits only. Depends on mdf_pkg, mdf_if, mdf_round, mdf_modmul.
module modular_division_fermat_top (
    input  logic i_clk,
    input  logic i_rst_n,
    mdf_in_if.sink    i_in,
    mdf_out_if.source o_out
);
    import mdf_pkg::*;

    localparam int unsigned DEPTH = 1 + ROUNDS * MUL_LAT;

    logic           en;
    logic [DEPTH-1:0] r_vld;
    t_word          r_acc0;
    t_word          r_base0;
    t_word          acc  [ROUNDS+1];
    t_word          base [ROUNDS];

    assign en = !r_vld[DEPTH-1] || o_out.ready;
    assign i_in.ready = en;

    // Move valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_in.valid};
        end
    end

    // Reduce operands below the prime
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_acc0  <= (i_in.dividend >= PRIME) ? i_in.dividend - PRIME : i_in.dividend;
            r_base0 <= (i_in.divisor >= PRIME) ? i_in.divisor - PRIME : i_in.divisor;
        end
    end

    assign acc[0]  = r_acc0;
    assign base[0] = r_base0;

    generate
        for (genvar r = 0; r < ROUNDS; r++) begin : g_rnd
            if (r < ROUNDS - 1) begin : g_full
                mdf_round #(.DO_MUL(EXPO[r])) u_round (
                    .i_clk  (i_clk),
                    .i_en   (en),
                    .i_acc  (acc[r]),
                    .i_base (base[r]),
                    .o_acc  (acc[r+1]),
                    .o_base (base[r+1])
                );
            end else begin : g_last
                // Top exponent bit is set; the final square is not needed
                mdf_modmul u_mul (
                    .i_clk (i_clk),
                    .i_en  (en),
                    .i_a   (acc[r]),
                    .i_b   (base[r]),
                    .o_p   (acc[r+1])
                );
            end
        end
    endgenerate

    assign o_out.valid    = r_vld[DEPTH-1];
    assign o_out.quotient = acc[ROUNDS];
endmodule
